// File: hw/rtl/bdsc_pkg.sv
`default_nettype none

package bdsc_pkg;

  // Field widths of the stream payloads.
  localparam int YEAR_W     = 14;
  localparam int MON_W      = 4;
  localparam int DAY_W      = 5;
  localparam int CNT_W      = 22;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MASK_W     = 7;
  localparam logic [MASK_W-1:0] MASK_RESET = 7'd96;

  // Internal datapath widths.
  localparam int YX_W  = 15;  // year shifted by 400
  localparam int Q100_W = 8;  // shifted year / 100
  localparam int SER_W = 23;  // serial day number and span
  localparam int Q7_W  = 20;  // span / 7
  localparam int WD_W  = 3;   // weekday and remainder

  // Arithmetic constants.
  localparam logic [YX_W-1:0]  YEAR_SHIFT = 15'd400;
  localparam logic [12:0]      RECIP100   = 13'd5243;  // ceil(2^19 / 100)
  localparam int               RECIP100_SH = 19;
  localparam logic [23:0]      RECIP7     = 24'd9586981; // ceil(2^26 / 7)
  localparam int               RECIP7_SH  = 26;
  localparam logic [SER_W-1:0] DAYS_YEAR  = 23'd365;
  localparam logic [SER_W-1:0] WD_OFFSET  = 23'd3;    // serial day 0 is a Wednesday
  localparam logic [CNT_W-1:0] COUNT_MAX  = 22'h3FFFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new request
    logic date_sel;   // 0: start date, 1: end date
    logic div_leap;   // divide the plain shifted year by 100
    logic div_ser;    // divide the serial-form shifted year by 100
    logic chk_leap;   // decide the leap year and check the date
    logic ser_load;   // form the serial day number
    logic span_load;  // form the span and the start weekday
    logic div7_load;  // divide the span by 7
    logic rem_load;   // remainder and whole-week count
    logic out_load;   // load the result register
  } bdsc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_blocked;  // result register full and not taken this cycle
  } bdsc_status_t;

  // Days in month m; 0 for a month outside 1..12.
  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    if (!(m inside {[4'd1:4'd12]})) begin
      len = 5'd0;
    end else if (m == 4'd2) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

  // Days from March 1 to the first of month m, March-based year.
  function automatic logic [8:0] month_offset(input logic [MON_W-1:0] m);
    logic [8:0] off;
    case (m)
      4'd1:    off = 9'd306;
      4'd2:    off = 9'd337;
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

  // Remainder by 7 through octal digit folding, since 8 = 1 mod 7.
  function automatic logic [WD_W-1:0] mod7(input logic [SER_W-1:0] v);
    logic [SER_W:0] w;
    logic [5:0]     sum;
    logic [3:0]     fold;
    logic [3:0]     res;
    w   = {1'b0, v};
    sum = 6'd0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + 6'(w[3*i +: 3]);
    end
    fold = 4'(sum[2:0]) + 4'(sum[5:3]);
    if (fold >= 4'd14) begin
      res = fold - 4'd14;
    end else if (fold >= 4'd7) begin
      res = fold - 4'd7;
    end else begin
      res = fold;
    end
    return res[WD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bdsc_ctrl.sv
`default_nettype none

module bdsc_ctrl import bdsc_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire bdsc_status_t  status,
  output bdsc_cmd_t          cmd
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_DIVL = 8'b0000_0010,
    ST_LEAP = 8'b0000_0100,
    ST_SER  = 8'b0000_1000,
    ST_SPAN = 8'b0001_0000,
    ST_DIV7 = 8'b0010_0000,
    ST_REM  = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   end_pass_r, end_pass_nxt;

  // State and date pass registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      end_pass_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      end_pass_r <= end_pass_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  // Sequencing: each date takes three steps, then span, divide, remainder, result.
  always_comb begin
    state_nxt    = state_r;
    end_pass_nxt = end_pass_r;
    cmd          = '0;
    cmd.date_sel = end_pass_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load     = 1'b1;
          end_pass_nxt = 1'b0;
          state_nxt    = ST_DIVL;
        end
      end
      ST_DIVL: begin
        cmd.div_leap = 1'b1;
        state_nxt    = ST_LEAP;
      end
      ST_LEAP: begin
        cmd.chk_leap = 1'b1;
        cmd.div_ser  = 1'b1;
        state_nxt    = ST_SER;
      end
      ST_SER: begin
        cmd.ser_load = 1'b1;
        if (end_pass_r) begin
          state_nxt = ST_SPAN;
        end else begin
          end_pass_nxt = 1'b1;
          state_nxt    = ST_DIVL;
        end
      end
      ST_SPAN: begin
        cmd.span_load = 1'b1;
        state_nxt     = ST_DIV7;
      end
      ST_DIV7: begin
        cmd.div7_load = 1'b1;
        state_nxt     = ST_REM;
      end
      ST_REM: begin
        cmd.rem_load = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (!status.out_blocked) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/bdsc_dp.sv
`default_nettype none

module bdsc_dp import bdsc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [MASK_W-1:0]     mask,
  input  wire bdsc_cmd_t             cmd,
  output bdsc_status_t               status,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  // Captured request.
  logic [YEAR_W-1:0] sy_r, ey_r;
  logic [MON_W-1:0]  sm_r, em_r;
  logic [DAY_W-1:0]  sd_r, ed_r;

  // Shared divide-by-100 stage and per-date results.
  logic [YX_W-1:0]   x_r;
  logic [Q100_W-1:0] q_r;
  logic              s_ok_r, e_ok_r;
  logic [SER_W-1:0]  s_ser_r, e_ser_r;

  // Span stages.
  logic              nonempty_r;
  logic [SER_W-1:0]  span_r;
  logic [WD_W-1:0]   wd_r;
  logic [Q7_W-1:0]   q7_r;
  logic [WD_W-1:0]   rest_r;
  logic [SER_W-1:0]  wk_r;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  out_cnt_r;
  logic              out_bad_r;

  // Selected date.
  logic [YEAR_W-1:0] y_sel;
  logic [MON_W-1:0]  m_sel;
  logic [DAY_W-1:0]  d_sel;
  logic              early;
  logic [YX_W-1:0]   x_in;
  logic [27:0]       prod100;
  logic [Q100_W-1:0] q_in;

  // Leap year and date check.
  logic [YX_W-1:0]   rem100;
  logic              leap;
  logic              date_ok;
  logic [SER_W-1:0]  ser_val;

  // Span arithmetic.
  logic [46:0]       prod7;
  logic [SER_W-1:0]  rem_full;
  logic [WD_W-1:0]   per_week;
  logic [2*MASK_W-1:0] rot_wide;
  logic [MASK_W-1:0] rot;
  logic [WD_W-1:0]   extra;
  logic [SER_W-1:0]  cnt_sum;
  logic [CNT_W-1:0]  cnt_sat;
  logic              bad;
  logic [CNT_W-1:0]  cnt_final;

  // Pick the date that the current pass works on.
  always_comb begin
    y_sel = cmd.date_sel ? ey_r : sy_r;
    m_sel = cmd.date_sel ? em_r : sm_r;
    d_sel = cmd.date_sel ? ed_r : sd_r;
  end

  // January and February count to the previous March-based year.
  assign early   = (m_sel <= 4'd2);
  assign x_in    = YX_W'(y_sel) + YEAR_SHIFT - YX_W'(cmd.div_ser & early);
  assign prod100 = 28'(x_in) * 28'(RECIP100);
  assign q_in    = prod100[RECIP100_SH +: Q100_W];

  // The shifted year keeps the remainders by 4, 100 and 400 of the year.
  assign rem100 = x_r - YX_W'(q_r) * YX_W'(100);
  assign leap   = ((x_r[1:0] == 2'd0) && (rem100 != '0)) ||
                  ((rem100 == '0) && (q_r[1:0] == 2'd0));
  assign date_ok = (d_sel >= 5'd1) && (d_sel <= month_len(m_sel, leap));

  // Serial day number from the registered quotient.
  assign ser_val = SER_W'(x_r) * DAYS_YEAR + SER_W'(x_r >> 2) - SER_W'(q_r)
                 + SER_W'(q_r >> 2) + SER_W'(month_offset(m_sel)) + SER_W'(d_sel)
                 - SER_W'(1);

  // Whole weeks and the days left over.
  assign prod7    = 47'(span_r) * 47'(RECIP7);
  assign rem_full = span_r - SER_W'(q7_r) * SER_W'(7);
  assign per_week = WD_W'(MASK_W - $countones(mask));

  // Business days among the leftover days, starting at the start weekday.
  always_comb begin
    rot_wide = {mask, mask} >> wd_r;
    rot      = rot_wide[MASK_W-1:0];
    extra    = '0;
    for (int k = 0; k < MASK_W; k++) begin
      if ((WD_W'(k) < rest_r) && !rot[k]) begin
        extra = extra + WD_W'(1);
      end
    end
  end

  // Final count with saturation and the special cases.
  always_comb begin
    cnt_sum = wk_r + SER_W'(extra);
    cnt_sat = (cnt_sum > SER_W'(COUNT_MAX)) ? COUNT_MAX : cnt_sum[CNT_W-1:0];
    bad     = !(s_ok_r && e_ok_r);
    if (bad || !nonempty_r) begin
      cnt_final = '0;
    end else begin
      cnt_final = cnt_sat;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sy_r <= in_tdata[13:0];
      sm_r <= in_tdata[17:14];
      sd_r <= in_tdata[22:18];
      ey_r <= in_tdata[36:23];
      em_r <= in_tdata[40:37];
      ed_r <= in_tdata[45:41];
    end
    if (cmd.div_leap || cmd.div_ser) begin
      x_r <= x_in;
      q_r <= q_in;
    end
    if (cmd.chk_leap) begin
      if (cmd.date_sel) begin
        e_ok_r <= date_ok;
      end else begin
        s_ok_r <= date_ok;
      end
    end
    if (cmd.ser_load) begin
      if (cmd.date_sel) begin
        e_ser_r <= ser_val;
      end else begin
        s_ser_r <= ser_val;
      end
    end
    if (cmd.span_load) begin
      nonempty_r <= (s_ser_r < e_ser_r);
      span_r     <= e_ser_r - s_ser_r;
      wd_r       <= mod7(s_ser_r + WD_OFFSET);
    end
    if (cmd.div7_load) begin
      q7_r <= prod7[RECIP7_SH +: Q7_W];
    end
    if (cmd.rem_load) begin
      rest_r <= rem_full[WD_W-1:0];
      wk_r   <= SER_W'(q7_r) * SER_W'(per_week);
    end
    if (cmd.out_load) begin
      out_cnt_r <= cnt_final;
      out_bad_r <= bad;
    end
  end

  // Result valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign status.out_blocked = out_valid_r && !out_tready;
  assign out_tvalid         = out_valid_r;
  assign out_tdata          = {1'b0, out_bad_r, out_cnt_r};

endmodule

`default_nettype wire

// File: hw/rtl/business_day_span_counter.sv
// Channel  | Direction | Ports                         | Carries
// ---------+-----------+-------------------------------+------------------------------
// in_      | slave     | tvalid, tready, tdata[47:0]   | start and end dates
// out_     | master    | tvalid, tready, tdata[23:0]   | business day count, bad flag
// cfg_     | APB slave | psel, penable, pwrite, paddr, | weekend mask at address 0
//          |           | pwdata, prdata, pready        |
//
// After a request is accepted, the result is loaded after three steps per date
// through one shared divide-by-100 stage, then span, divide-by-7, remainder and
// result steps. The controller takes no new request until the result is loaded.
// Reset is synchronous and active low; it clears the controller and the result
// valid flag and sets the weekend mask to Friday plus Saturday.
// A stalled result holds the controller in its last step until the slot frees.
`default_nettype none

module business_day_span_counter import bdsc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Input stream.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // Fields from bit 0: start_year[13:0], start_month[17:14], start_day[22:18],
  // end_year[36:23], end_month[40:37], end_day[45:41], zero fill [47:46].
  input  wire logic [IN_DATA_W-1:0]   in_tdata,
  // Result stream.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // Fields from bit 0: business_days[21:0], bad_date[22], zero fill [23].
  output logic [OUT_DATA_W-1:0]       out_tdata,
  // Configuration port.
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]       cfg_prdata,
  output logic                        cfg_pready
);

  logic [MASK_W-1:0] mask_r;
  logic              cfg_wr;
  logic              mask_hit;
  bdsc_cmd_t         cmd;
  bdsc_status_t      status;

  // Register decode: the weekend mask is the only register.
  assign cfg_pready = 1'b1;
  assign mask_hit   = (cfg_paddr[CFG_ADDR_W-1] == 1'b0);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= MASK_RESET;
    end else if (cfg_wr && mask_hit) begin
      mask_r <= cfg_pwdata[MASK_W-1:0];
    end
  end

  assign cfg_prdata = mask_hit ? CFG_DATA_W'(mask_r) : '0;

  // Controller.
  bdsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath.
  bdsc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .mask       (mask_r),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// File: hw/rtl/bdsc_checker.sv
`default_nettype none

module bdsc_checker import bdsc_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result payload changed while stalled");

  // A bad date always reports a zero count.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[22] |-> out_tdata[21:0] == '0)
    else $error("bad date with nonzero count");

  // One request at a time: ready drops right after a request is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");

endmodule

bind business_day_span_counter bdsc_checker u_chk (.*);

`default_nettype wire

// File: bench/tb_business_day_span_counter.sv
`timescale 1ns / 1ps

module tb_business_day_span_counter;
  import bdsc_pkg::*;

  localparam int unsigned YEAR_TOP = 16383;
  localparam int unsigned DAYS_CAP = 4194303;
  localparam logic [CFG_ADDR_W-1:0] ADDR_WEEKEND_MASK = '0;
  localparam int unsigned RANDOM_PER_PHASE = 100;
  localparam int unsigned PHASES = 8;

  // Request payload, start_year in the lowest bits as on in_tdata.
  typedef struct packed {
    logic [DAY_W-1:0]  end_day;
    logic [MON_W-1:0]  end_month;
    logic [YEAR_W-1:0] end_year;
    logic [DAY_W-1:0]  start_day;
    logic [MON_W-1:0]  start_month;
    logic [YEAR_W-1:0] start_year;
  } date_span_t;

  typedef struct {
    logic [CNT_W-1:0] days;
    logic             bad;
  } span_count_t;

  // Ways the result side applies backpressure.
  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_TOGGLE
  } ready_style_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // Fields from bit 0: start_year, start_month, start_day, end_year, end_month,
  // end_day, zero fill.
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // Fields from bit 0: business_days, bad_date, zero fill.
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  date_span_t pending_spans[$];
  span_count_t expected_counts[$];
  logic [MASK_W-1:0] weekend_bits = MASK_RESET;
  int unsigned failures = 0;

  business_day_span_counter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  // Days in a month; zero for a month outside 1..12.
  function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
    bit leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      2: return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      1, 3, 5, 7, 8, 10, 12: return 31;
      default: return 0;
    endcase
  endfunction

  // Day number counted from a March-based epoch, year shifted by 400 to
  // keep year 0 and January/February positive.
  function automatic int unsigned day_number(input int unsigned y, input int unsigned m,
                                             input int unsigned d);
    int unsigned yy;
    int unsigned mm;
    yy = y + 400 - ((m <= 2) ? 1 : 0);
    mm = (m + 9) % 12;
    return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mm + 2) / 5 + d - 1;
  endfunction

  // Business days from the start date up to, not including, the end date.
  function automatic span_count_t predict_business_days(input date_span_t s,
                                                        input logic [MASK_W-1:0] mask);
    span_count_t r;
    int unsigned first;
    int unsigned last;
    int unsigned span;
    int unsigned total;
    int unsigned wd;
    int unsigned yy;
    int unsigned mm;
    int unsigned a;
    int unsigned k;
    r.days = '0;
    r.bad = 1'b0;
    if (s.start_day == 0 || s.start_day > month_days(s.start_year, s.start_month) ||
        s.end_day == 0 || s.end_day > month_days(s.end_year, s.end_month)) begin
      r.bad = 1'b1;
      return r;
    end
    first = day_number(s.start_year, s.start_month, s.start_day);
    last = day_number(s.end_year, s.end_month, s.end_day);
    if (first >= last) begin
      return r;
    end
    span = last - first;
    // Whole weeks first, then the leftover days walked from the start weekday.
    total = (span / 7) * (7 - $countones(mask));
    a = (14 - s.start_month) / 12;
    yy = s.start_year + 400 - a;
    mm = s.start_month + 12 * a - 2;
    wd = (s.start_day + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
    for (k = 0; k < span % 7; k++) begin
      if (!mask[wd]) begin
        total++;
      end
      wd = (wd + 1) % 7;
    end
    r.days = CNT_W'((total > DAYS_CAP) ? DAYS_CAP : total);
    return r;
  endfunction

  function automatic int unsigned rand_day(input int unsigned y, input int unsigned m);
    return $urandom_range(1, month_days(y, m));
  endfunction

  // Short spans within a year, spans into the next year, long spans, empty spans,
  // dates with one bad field and raw noise.
  function automatic date_span_t make_random_span();
    date_span_t s;
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    s.start_year = YEAR_W'($urandom_range(0, YEAR_TOP));
    s.start_month = MON_W'($urandom_range(1, 12));
    s.start_day = DAY_W'(rand_day(s.start_year, s.start_month));
    s.end_year = YEAR_W'($urandom_range(0, YEAR_TOP));
    s.end_month = MON_W'($urandom_range(1, 12));
    if (pick < 40) begin
      s.end_year = s.start_year;
      s.end_month = MON_W'((s.start_month + $urandom_range(0, 2) > 12) ?
                           12 : s.start_month + $urandom_range(0, 2));
    end else if (pick < 55) begin
      s.end_year = (s.start_year == YEAR_TOP) ? s.start_year : s.start_year + 1'b1;
    end
    s.end_day = DAY_W'(rand_day(s.end_year, s.end_month));
    if (pick >= 70 && pick < 75) begin
      s.end_year = s.start_year;
      s.end_month = s.start_month;
      s.end_day = s.start_day;
    end else if (pick >= 75 && pick < 87) begin
      case ($urandom_range(0, 3))
        0: s.start_month = MON_W'($urandom_range(13, 16));
        1: s.end_month = MON_W'($urandom_range(13, 16));
        2: begin
          len = month_days(s.start_year, s.start_month);
          s.start_day = DAY_W'((len == 31 || $urandom_range(0, 1)) ?
                               0 : $urandom_range(len + 1, 31));
        end
        default: begin
          len = month_days(s.end_year, s.end_month);
          s.end_day = DAY_W'((len == 31 || $urandom_range(0, 1)) ?
                             0 : $urandom_range(len + 1, 31));
        end
      endcase
    end else if (pick >= 87) begin
      s = date_span_t'({$urandom, $urandom});
    end
    return s;
  endfunction

  task automatic queue_span(input int unsigned sy, input int unsigned sm,
                            input int unsigned sd, input int unsigned ey,
                            input int unsigned em, input int unsigned ed);
    date_span_t s;
    s.start_year = YEAR_W'(sy);
    s.start_month = MON_W'(sm);
    s.start_day = DAY_W'(sd);
    s.end_year = YEAR_W'(ey);
    s.end_month = MON_W'(em);
    s.end_day = DAY_W'(ed);
    pending_spans.push_back(s);
  endtask

  task automatic cfg_write_mask(input logic [MASK_W-1:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_WEEKEND_MASK;
    cfg_pwdata <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    weekend_bits = value;
  endtask

  task automatic cfg_check_mask();
    logic [CFG_DATA_W-1:0] got;
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= ADDR_WEEKEND_MASK;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (got[MASK_W-1:0] !== weekend_bits) begin
      $error("weekend_mask: expected %h, actual %h", weekend_bits, got[MASK_W-1:0]);
      failures++;
    end
  endtask

  task automatic wait_idle();
    while (pending_spans.size() != 0 || expected_counts.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Request driver: bursts of random length separated by random gaps.
  int unsigned burst_left;
  int unsigned gap_left;
  logic offer;
  date_span_t sent;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      burst_left = $urandom_range(1, 16);
      gap_left = 0;
    end else begin
      offer = in_tvalid;
      if (in_tvalid && in_tready) begin
        sent = pending_spans.pop_front();
        expected_counts.push_back(predict_business_days(sent, weekend_bits));
        offer = 1'b0;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_spans.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= {2'b00, pending_spans[0]};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each result and stalls in changing styles.
  ready_style_t ready_style;
  int unsigned style_left;
  span_count_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_style = READY_ALWAYS;
      style_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_counts.size() == 0) begin
          $error("result with no request outstanding: tdata %h", out_tdata);
          failures++;
        end else begin
          want = expected_counts.pop_front();
          if (out_tdata[CNT_W-1:0] !== want.days) begin
            $error("business_days: expected %0d, actual %0d", want.days,
                   out_tdata[CNT_W-1:0]);
            failures++;
          end
          if (out_tdata[CNT_W] !== want.bad) begin
            $error("bad_date: expected %0d, actual %0d", want.bad, out_tdata[CNT_W]);
            failures++;
          end
        end
      end
      if (style_left == 0) begin
        ready_style = ready_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(16, 96);
      end else begin
        style_left--;
      end
      case (ready_style)
        READY_ALWAYS: out_tready <= 1'b1;
        READY_COIN:   out_tready <= 1'($urandom_range(0, 1));
        READY_SPARSE: out_tready <= ($urandom_range(0, 7) == 0);
        default:      out_tready <= ~out_tready;
      endcase
    end
  end

  // Stimulus: directed spans under the reset mask, then random phases.
  logic [MASK_W-1:0] phase_masks[PHASES] = '{7'h60, 7'h00, 7'h7F, 7'h01, 7'h41,
                                             7'h00, 7'h00, 7'h00};
  int unsigned phase;

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    cfg_check_mask();

    // Typical spans, empty and reversed spans, crossing a year end.
    queue_span(2024, 1, 1, 2024, 2, 1);
    queue_span(2024, 3, 15, 2024, 3, 15);
    queue_span(2024, 3, 16, 2024, 3, 15);
    queue_span(2023, 12, 31, 2024, 1, 1);
    // Leap rules: every fourth year, not centuries, but every 400 years; days past month end.
    queue_span(2024, 2, 29, 2024, 3, 1);
    queue_span(2000, 2, 29, 2000, 3, 7);
    queue_span(1900, 2, 29, 1900, 3, 1);
    queue_span(2023, 2, 29, 2023, 3, 1);
    queue_span(2024, 2, 30, 2024, 3, 1);
    queue_span(2024, 4, 31, 2024, 5, 1);
    // Bad months and days at both ends.
    queue_span(2024, 0, 1, 2024, 1, 1);
    queue_span(2024, 1, 1, 2024, 13, 1);
    queue_span(2024, 1, 1, 2024, 15, 31);
    queue_span(2024, 1, 0, 2024, 1, 5);
    queue_span(2024, 1, 1, 2024, 1, 0);
    // Year zero is a leap year; the full year range saturates the count.
    queue_span(0, 2, 29, 0, 3, 8);
    queue_span(0, 1, 1, YEAR_TOP, 12, 31);
    queue_span(YEAR_TOP, 12, 31, 0, 1, 1);
    // Spans just below and above one week, a span of whole weeks and long spans.
    queue_span(2024, 1, 31, 2024, 2, 6);
    queue_span(2024, 1, 31, 2024, 2, 8);
    queue_span(YEAR_TOP, 1, 1, YEAR_TOP, 12, 31);
    queue_span(1, 1, 1, 9999, 12, 31);

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        wait_idle();
        repeat (16) @(posedge clk);
        cfg_write_mask((phase >= 5) ? MASK_W'($urandom_range(0, 127)) : phase_masks[phase]);
        cfg_check_mask();
        queue_span(0, 1, 1, YEAR_TOP, 12, 31);
      end
      repeat (RANDOM_PER_PHASE) pending_spans.push_back(make_random_span());
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
